FILE: rtl/fat12ct_pkg.sv
`timescale 1ns / 1ps

package fat12ct_pkg;

   // Table geometry.
   localparam int MAX_CLUSTERS  = 4096;
   localparam int ADDR_WIDTH    = $clog2(MAX_CLUSTERS);

   // Field widths.
   localparam int CLUSTER_WIDTH = 12;
   localparam int SPC_WIDTH     = 8;
   localparam int SECTORS_WIDTH = 19;
   localparam int REQ_WIDTH     = 2;
   localparam int CSR_IDX_WIDTH = 2;

   // Scan cursor and scan end hold values up to 2 + data cluster count.
   localparam int SCAN_WIDTH    = CLUSTER_WIDTH + 1;

   localparam logic [SCAN_WIDTH-1:0]    FIRST_DATA_CLUSTER = SCAN_WIDTH'(2);
   localparam logic [SECTORS_WIDTH-1:0] SECTORS_MAX        = {SECTORS_WIDTH{1'b1}};

   // Request codes.
   localparam logic [REQ_WIDTH-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_WIDTH-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_WIDTH-1:0] REQ_FIND  = 2'd2;
   localparam logic [REQ_WIDTH-1:0] REQ_COUNT = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DATA_CLUSTER_COUNT  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECTORS_PER_CLUSTER = 2'd1;

   localparam logic [CLUSTER_WIDTH-1:0] DCC_RESET = 12'd4084;
   localparam logic [SPC_WIDTH-1:0]     SPC_RESET = 8'd1;

   typedef struct packed {
      logic [CLUSTER_WIDTH-1:0] data_cluster_count;
      logic [SPC_WIDTH-1:0]     sectors_per_cluster;
   } cfg_type;

   typedef struct packed {
      logic                     wr_en;
      logic                     rd_en;
      logic [ADDR_WIDTH-1:0]    addr;
      logic [CLUSTER_WIDTH-1:0] wr_data;
   } ram_cmd_type;

endpackage

FILE: rtl/fat12_cluster_table.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------------------
// req      | in        | req_valid / req_ready | req_type, req_cluster_index,
//          |           |                       | req_entry_value
// rsp      | out       | rsp_valid / rsp_ready | rsp_read_value, rsp_free_cluster,
//          |           |                       | rsp_free_sectors
// csr      | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// Reads and writes make one RAM access each, while find and count requests
// walk the data clusters one table entry per cycle through the
// single RAM port; a find stops at the first free cluster it sees.
// After reset a clearing pass writes zero to all 4096 entries, one per cycle;
// req_ready stays low during the pass, while csr writes are taken.
// One request is worked on at a time. The output register lets the next
// transaction be accepted while an earlier result waits on rsp_ready.
module fat12_cluster_table
   import fat12ct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [REQ_WIDTH-1:0]     req_type,
   input  logic [CLUSTER_WIDTH-1:0] req_cluster_index,
   input  logic [CLUSTER_WIDTH-1:0] req_entry_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CLUSTER_WIDTH-1:0] rsp_read_value,
   output logic [CLUSTER_WIDTH-1:0] rsp_free_cluster,
   output logic [SECTORS_WIDTH-1:0] rsp_free_sectors,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CLUSTER_WIDTH-1:0] csr_wdata
);

   cfg_type                  cfg;
   ram_cmd_type              ram_cmd;
   logic [CLUSTER_WIDTH-1:0] ram_rd_data;

   // Configuration registers: data cluster count and sectors per cluster.
   fat12ct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Request sequencer: clearing pass, entry access, table walk and the
   // output register.
   fat12ct_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_cluster_index (req_cluster_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_free_cluster  (rsp_free_cluster),
      .rsp_free_sectors  (rsp_free_sectors),
      .ram_cmd           (ram_cmd),
      .ram_rd_data       (ram_rd_data)
   );

   // The allocation table itself. Only one request is active at a time, so
   // a read never meets a write to the same entry in the same cycle.
   fat12ct_ram #(
      .Width (CLUSTER_WIDTH),
      .Depth (MAX_CLUSTERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .rd_en   (ram_cmd.rd_en),
      .addr    (ram_cmd.addr),
      .wr_data (ram_cmd.wr_data),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: rtl/fat12ct_ram.sv
`timescale 1ns / 1ps

// Simple single-address RAM with a registered read. A read and a write in the
// same cycle return the old contents.
module fat12ct_ram #(
   parameter int Width = 12,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fat12ct_csr.sv
`timescale 1ns / 1ps

module fat12ct_csr
   import fat12ct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CLUSTER_WIDTH-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes to an index past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DATA_CLUSTER_COUNT) begin
            cfg_in.data_cluster_count = csr_wdata;
         end else if (csr_index == CSR_SECTORS_PER_CLUSTER) begin
            cfg_in.sectors_per_cluster = csr_wdata[SPC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_cluster_count  <= DCC_RESET;
         cfg_ff.sectors_per_cluster <= SPC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: rtl/fat12ct_engine.sv
`timescale 1ns / 1ps

module fat12ct_engine
   import fat12ct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [REQ_WIDTH-1:0]     req_type,
   input  logic [CLUSTER_WIDTH-1:0] req_cluster_index,
   input  logic [CLUSTER_WIDTH-1:0] req_entry_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CLUSTER_WIDTH-1:0] rsp_read_value,
   output logic [CLUSTER_WIDTH-1:0] rsp_free_cluster,
   output logic [SECTORS_WIDTH-1:0] rsp_free_sectors,
   output ram_cmd_type              ram_cmd,
   input  logic [CLUSTER_WIDTH-1:0] ram_rd_data
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [SCAN_WIDTH-1:0] SCAN_LIMIT = SCAN_WIDTH'(MAX_CLUSTERS);
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR  = ADDR_WIDTH'(MAX_CLUSTERS - 1);

   logic [2:0]               state_ff, state_in;
   logic [ADDR_WIDTH-1:0]    clr_ff, clr_in;
   logic [SCAN_WIDTH-1:0]    cursor_ff, cursor_in;
   logic [SCAN_WIDTH-1:0]    end_ff, end_in;
   logic [ADDR_WIDTH-1:0]    rd_addr_ff, rd_addr_in;
   logic                     pend_ff, pend_in;
   logic                     find_ff, find_in;
   logic                     idx_ok_ff, idx_ok_in;
   logic [CLUSTER_WIDTH-1:0] res_read_ff, res_read_in;
   logic [CLUSTER_WIDTH-1:0] res_free_ff, res_free_in;
   logic [SECTORS_WIDTH-1:0] res_sect_ff, res_sect_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_WIDTH-1:0] rsp_read_ff, rsp_read_in;
   logic [CLUSTER_WIDTH-1:0] rsp_free_ff, rsp_free_in;
   logic [SECTORS_WIDTH-1:0] rsp_sect_ff, rsp_sect_in;

   logic                     accept;
   logic                     idx_in_range;
   logic [SCAN_WIDTH-1:0]    scan_sum;
   logic [SECTORS_WIDTH:0]   sect_sum;
   logic                     hit;
   logic                     out_free;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign idx_in_range = ({1'b0, req_cluster_index} < SCAN_LIMIT);
   assign scan_sum     = FIRST_DATA_CLUSTER + SCAN_WIDTH'(cfg.data_cluster_count);
   assign sect_sum     = {1'b0, res_sect_ff} + (SECTORS_WIDTH + 1)'(cfg.sectors_per_cluster);
   assign hit          = pend_ff && (ram_rd_data == '0);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      end_in       = end_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = pend_ff;
      find_in      = find_ff;
      idx_ok_in    = idx_ok_ff;
      res_read_in  = res_read_ff;
      res_free_in  = res_free_ff;
      res_sect_in  = res_sect_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_read_in  = rsp_read_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_sect_in  = rsp_sect_ff;
      ram_cmd      = '{wr_en: 1'b0, rd_en: 1'b0, addr: req_cluster_index[ADDR_WIDTH-1:0],
                       wr_data: req_entry_value};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.addr    = clr_ff;
            ram_cmd.wr_data = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_read_in = '0;
               res_free_in = '0;
               res_sect_in = '0;
               unique case (req_type)
                  REQ_READ: begin
                     ram_cmd.rd_en = 1'b1;
                     idx_ok_in     = idx_in_range;
                     state_in      = ST_READ;
                  end
                  REQ_WRITE: begin
                     ram_cmd.wr_en = idx_in_range;
                     state_in      = ST_FINISH;
                  end
                  REQ_FIND, REQ_COUNT: begin
                     find_in   = (req_type == REQ_FIND);
                     cursor_in = FIRST_DATA_CLUSTER;
                     end_in    = (scan_sum > SCAN_LIMIT) ? SCAN_LIMIT : scan_sum;
                     pend_in   = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_read_in = idx_ok_ff ? ram_rd_data : '0;
            state_in    = ST_FINISH;
         end
         ST_SCAN: begin
            if (find_ff && hit) begin
               res_free_in = CLUSTER_WIDTH'(rd_addr_ff);
               pend_in     = 1'b0;
               state_in    = ST_FINISH;
            end else begin
               if (hit) begin
                  res_sect_in = (sect_sum > (SECTORS_WIDTH + 1)'(SECTORS_MAX)) ?
                                SECTORS_MAX : sect_sum[SECTORS_WIDTH-1:0];
               end
               if (cursor_ff < end_ff) begin
                  ram_cmd.rd_en = 1'b1;
                  ram_cmd.addr  = cursor_ff[ADDR_WIDTH-1:0];
                  rd_addr_in    = cursor_ff[ADDR_WIDTH-1:0];
                  cursor_in     = cursor_ff + 1'b1;
                  pend_in       = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = res_read_ff;
               rsp_free_in  = res_free_ff;
               rsp_sect_in  = res_sect_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff   <= cursor_in;
      end_ff      <= end_in;
      rd_addr_ff  <= rd_addr_in;
      find_ff     <= find_in;
      idx_ok_ff   <= idx_ok_in;
      res_read_ff <= res_read_in;
      res_free_ff <= res_free_in;
      res_sect_ff <= res_sect_in;
      rsp_read_ff <= rsp_read_in;
      rsp_free_ff <= rsp_free_in;
      rsp_sect_ff <= rsp_sect_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_free_cluster = rsp_free_ff;
   assign rsp_free_sectors = rsp_sect_ff;

endmodule

FILE: rtl/fat12ct_checker.sv
`timescale 1ns / 1ps

module fat12ct_checker
   import fat12ct_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CLUSTER_WIDTH-1:0] rsp_read_value,
   input logic [CLUSTER_WIDTH-1:0] rsp_free_cluster,
   input logic [SECTORS_WIDTH-1:0] rsp_free_sectors
);

   // Transactions accepted on req but not yet delivered on rsp.
   logic [1:0] open_ff;
   logic [1:0] open_in;

   always_comb begin
      open_in = open_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         open_in = open_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A result waiting on the consumer stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction completed");

   // No result appears without a request behind it, and at most two are open.
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || (open_ff != 2'd0)) && (open_ff != 2'd3))
      else $error("response count does not match accepted requests");

   // Each request kind fills at most one result field.
   a_one_field : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_read_value != '0, rsp_free_cluster != '0,
                                 rsp_free_sectors != '0}) <= 1))
      else $error("more than one result field is nonzero");

   // Cluster 1 is never reported as a free data cluster; 0 means none was found.
   a_no_cluster_one : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_cluster != CLUSTER_WIDTH'(1)))
      else $error("cluster 1 reported as free");

   // The clearing pass holds off requests right after reset.
   a_clear_blocks : assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

bind fat12_cluster_table fat12ct_checker u_checker (.*);

FILE: tb/sv/fat12_cluster_table_checker.sv
`timescale 1ns / 1ps

module fat12_cluster_table_checker
   import fat12ct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [REQ_WIDTH-1:0]     req_type,
   input  logic [CLUSTER_WIDTH-1:0] req_cluster_index,
   input  logic [CLUSTER_WIDTH-1:0] req_entry_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [CLUSTER_WIDTH-1:0] rsp_read_value,
   input  logic [CLUSTER_WIDTH-1:0] rsp_free_cluster,
   input  logic [SECTORS_WIDTH-1:0] rsp_free_sectors,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CLUSTER_WIDTH-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       responses_owed
);

   typedef struct packed {
      logic [CLUSTER_WIDTH-1:0] read_value;
      logic [CLUSTER_WIDTH-1:0] free_cluster;
      logic [SECTORS_WIDTH-1:0] free_sectors;
   } fat_response_type;

   logic [CLUSTER_WIDTH-1:0] shadow_fat [MAX_CLUSTERS];
   logic [CLUSTER_WIDTH-1:0] scan_length;
   logic [SPC_WIDTH-1:0]     cluster_weight;
   fat_response_type         owed_responses [$];

   // One past the last cluster a find or count looks at.
   function automatic int scan_stop();
      int last;
      last = int'(FIRST_DATA_CLUSTER) + int'(scan_length);
      return (last > MAX_CLUSTERS) ? MAX_CLUSTERS : last;
   endfunction

   // Applies one request to the shadow table and returns the response it must produce.
   function automatic fat_response_type serve_fat_request(
      input logic [REQ_WIDTH-1:0]     kind,
      input logic [CLUSTER_WIDTH-1:0] cluster,
      input logic [CLUSTER_WIDTH-1:0] value
   );
      fat_response_type rsp;
      int               sectors;
      int               c;
      rsp     = '0;
      sectors = 0;
      case (kind)
         REQ_READ: begin
            rsp.read_value = shadow_fat[cluster];
         end
         REQ_WRITE: begin
            shadow_fat[cluster] = value;
         end
         REQ_FIND: begin
            for (c = int'(FIRST_DATA_CLUSTER); c < scan_stop(); c++) begin
               if (shadow_fat[c] == '0) begin
                  rsp.free_cluster = c[CLUSTER_WIDTH-1:0];
                  break;
               end
            end
         end
         default: begin
            for (c = int'(FIRST_DATA_CLUSTER); c < scan_stop(); c++) begin
               if (shadow_fat[c] == '0) begin
                  sectors += int'(cluster_weight);
                  if (sectors > int'(SECTORS_MAX))
                     sectors = int'(SECTORS_MAX);
               end
            end
            rsp.free_sectors = sectors[SECTORS_WIDTH-1:0];
         end
      endcase
      return rsp;
   endfunction

   task automatic compare_field(
      input string                    field_name,
      input logic [SECTORS_WIDTH-1:0] want,
      input logic [SECTORS_WIDTH-1:0] got
   );
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      fat_response_type head;
      if (reset) begin
         foreach (shadow_fat[i])
            shadow_fat[i] = '0;
         scan_length    = DCC_RESET;
         cluster_weight = SPC_RESET;
         owed_responses.delete();
         mismatch_count = 0;
      end else begin
         // The oldest response leaves before this edge's request is added.
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none expected, actual %0d %0d %0d", $time,
                        rsp_read_value, rsp_free_cluster, rsp_free_sectors);
            end else begin
               head = owed_responses.pop_front();
               compare_field("read_value", SECTORS_WIDTH'(head.read_value),
                             SECTORS_WIDTH'(rsp_read_value));
               compare_field("free_cluster", SECTORS_WIDTH'(head.free_cluster),
                             SECTORS_WIDTH'(rsp_free_cluster));
               compare_field("free_sectors", head.free_sectors, rsp_free_sectors);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DATA_CLUSTER_COUNT:  scan_length    = csr_wdata;
               CSR_SECTORS_PER_CLUSTER: cluster_weight = csr_wdata[SPC_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            owed_responses.push_back(
               serve_fat_request(req_type, req_cluster_index, req_entry_value));
      end
      responses_owed = owed_responses.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fat12ct_pkg::*;

   // Register indexes that map to nothing; writes to them must leave the table alone.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   localparam int RESET_CYCLES      = 12;
   localparam int SETTLE_CYCLES     = 8;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int SEGMENT_ITEMS     = 200;
   localparam int HOT_CLUSTERS      = 64;
   // The clearing pass after reset and a full-table count each keep every channel
   // quiet while they walk the table, so the watchdog limit is set well above that.
   localparam int QUIET_LIMIT       = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [REQ_WIDTH-1:0]     req_type;
   logic [CLUSTER_WIDTH-1:0] req_cluster_index;
   logic [CLUSTER_WIDTH-1:0] req_entry_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [CLUSTER_WIDTH-1:0] rsp_read_value;
   logic [CLUSTER_WIDTH-1:0] rsp_free_cluster;
   logic [SECTORS_WIDTH-1:0] rsp_free_sectors;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CLUSTER_WIDTH-1:0] csr_wdata;

   int mismatch_count;
   int responses_owed;

   // Percent of cycles in which each side holds back.
   int req_idle_pct;
   int rsp_idle_pct;
   // Set by the stimulus to make the response side stop accepting for a long stretch.
   bit long_stall_request;

   fat12_cluster_table dut (.*);

   fat12_cluster_table_checker table_watch (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sends one request and returns at the edge where the transaction is accepted.
   // Valid is left high so that a following request goes out back to back.
   task automatic send_request(
      input logic [REQ_WIDTH-1:0]     kind,
      input logic [CLUSTER_WIDTH-1:0] cluster,
      input logic [CLUSTER_WIDTH-1:0] value
   );
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_cluster_index <= cluster;
      req_entry_value   <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(
      input logic [CSR_IDX_WIDTH-1:0] index,
      input logic [CLUSTER_WIDTH-1:0] data
   );
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering requests and waits for every owed response. The count is
   // sampled on the falling edge, after the checker has settled the rising one.
   // Every request yields a response, so the wait ends once the last one is delivered.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (responses_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic tuned to the current scan length. Most indexes land in the
   // low clusters so that writes keep filling and freeing what find and count
   // walk over; the rest cover the whole table. Counts are rare when the scan
   // is long, since each one walks the full range.
   task automatic run_random_requests(input int items, input int scan_span);
      int                       roll;
      int                       hot_top;
      int                       count_pct;
      logic [REQ_WIDTH-1:0]     kind;
      logic [CLUSTER_WIDTH-1:0] cluster;
      logic [CLUSTER_WIDTH-1:0] value;
      hot_top   = (scan_span + 3 < HOT_CLUSTERS) ? scan_span + 3 : HOT_CLUSTERS - 1;
      count_pct = (scan_span > HOT_CLUSTERS) ? 2 : 15;
      for (int i = 0; i < items; i++) begin
         // Halfway through, the sender waits until the block has answered everything.
         if (i == items / 2)
            wait_for_idle();
         roll = $urandom_range(99);
         if (roll < 35)
            kind = REQ_READ;
         else if (roll < 70)
            kind = REQ_WRITE;
         else if (roll < 100 - count_pct)
            kind = REQ_FIND;
         else
            kind = REQ_COUNT;
         if ($urandom_range(99) < 80)
            cluster = CLUSTER_WIDTH'($urandom_range(hot_top, 0));
         else
            cluster = CLUSTER_WIDTH'($urandom_range(MAX_CLUSTERS - 1, 0));
         if ($urandom_range(99) < 40)
            value = '0;
         else
            value = CLUSTER_WIDTH'($urandom_range(MAX_CLUSTERS - 1, 0));
         send_request(kind, cluster, value);
      end
   endtask

   // Response side. A long stall is counted here, so the request side keeps
   // offering transactions until the block fills up and drops req_ready.
   initial begin
      bit stall_done;
      stall_done = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_request && !stall_done) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: ends the run when no transaction has moved on any channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("fat12_cluster_table: mismatch");
      $finish;
   end

   initial begin
      logic [CLUSTER_WIDTH-1:0] span;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = REQ_READ;
      req_cluster_index  = '0;
      req_entry_value    = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_DATA_CLUSTER_COUNT;
      csr_wdata          = '0;
      long_stall_request = 1'b0;
      // The sender idles a little and the receiver a lot, first in the directed part.
      req_idle_pct       = 8;
      rsp_idle_pct       = 74;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset settings first: scan 4084 clusters, one sector each.
      // The block clears the table before it takes the first request.
      send_request(REQ_READ, 12'd0, 12'd0);
      send_request(REQ_READ, 12'hFFF, 12'hFFF);
      send_request(REQ_WRITE, 12'd0, 12'hFFF);
      send_request(REQ_WRITE, 12'hFFF, 12'hFFF);
      send_request(REQ_WRITE, 12'd1, 12'h555);
      send_request(REQ_READ, 12'd0, 12'd0);
      send_request(REQ_READ, 12'd1, 12'd0);
      send_request(REQ_READ, 12'hFFF, 12'd0);
      // Clusters 0 and 1 are in use but never scanned, so find still answers 2.
      send_request(REQ_FIND, 12'd0, 12'd0);
      send_request(REQ_WRITE, 12'd2, 12'hAAA);
      send_request(REQ_FIND, 12'd0, 12'd0);
      send_request(REQ_COUNT, 12'd0, 12'd0);

      // Three-cluster scan, 128 sectors per cluster. The upper write bits of the
      // sectors register are dropped, and a write to a spare index does nothing.
      wait_for_idle();
      write_register(CSR_DATA_CLUSTER_COUNT, 12'd3);
      write_register(CSR_SECTORS_PER_CLUSTER, 12'hF80);
      write_register(CSR_SPARE_2, 12'hFFF);
      send_request(REQ_WRITE, 12'd3, 12'hFF8);
      send_request(REQ_WRITE, 12'd4, 12'h007);
      // Every scanned cluster is taken: find gives 0 and count gives 0.
      send_request(REQ_FIND, 12'd0, 12'd0);
      send_request(REQ_COUNT, 12'd0, 12'd0);
      send_request(REQ_WRITE, 12'd4, 12'd0);
      send_request(REQ_FIND, 12'd0, 12'd0);
      send_request(REQ_COUNT, 12'd0, 12'd0);

      // An empty scan range finds nothing and counts nothing.
      wait_for_idle();
      write_register(CSR_DATA_CLUSTER_COUNT, 12'd0);
      send_request(REQ_FIND, 12'd0, 12'd0);
      send_request(REQ_COUNT, 12'd0, 12'd0);

      // Largest scan length runs past the table end. With zero sectors per
      // cluster the count is 0; with 255 it saturates.
      wait_for_idle();
      write_register(CSR_DATA_CLUSTER_COUNT, 12'hFFF);
      write_register(CSR_SECTORS_PER_CLUSTER, 12'h000);
      write_register(CSR_SPARE_3, 12'h0AB);
      send_request(REQ_COUNT, 12'd0, 12'd0);
      wait_for_idle();
      write_register(CSR_SECTORS_PER_CLUSTER, 12'h0FF);
      send_request(REQ_COUNT, 12'd0, 12'd0);
      send_request(REQ_FIND, 12'd0, 12'd0);

      // Random part, first segment: short scan, idling as in the directed part.
      // It opens with a long response stall so the block backs up into the
      // request channel.
      wait_for_idle();
      span = CLUSTER_WIDTH'($urandom_range(40, 8));
      write_register(CSR_DATA_CLUSTER_COUNT, span);
      write_register(CSR_SECTORS_PER_CLUSTER, CLUSTER_WIDTH'($urandom_range(128, 1)));
      long_stall_request = 1'b1;
      run_random_requests(SEGMENT_ITEMS, int'(span));

      // Second segment: the scan length of a full-size volume, with the idle
      // rates swapped so the sender is the slow side.
      wait_for_idle();
      req_idle_pct = 74;
      rsp_idle_pct = 8;
      span = DCC_RESET;
      write_register(CSR_DATA_CLUSTER_COUNT, span);
      write_register(CSR_SECTORS_PER_CLUSTER, 12'd128);
      run_random_requests(SEGMENT_ITEMS, int'(span));

      // Third segment: a tiny scan that fills up often, heaviest cluster weight,
      // and no idling on either side.
      wait_for_idle();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      span = CLUSTER_WIDTH'($urandom_range(16, 1));
      write_register(CSR_DATA_CLUSTER_COUNT, span);
      write_register(CSR_SECTORS_PER_CLUSTER, 12'd255);
      run_random_requests(SEGMENT_ITEMS, int'(span));

      wait_for_idle();
      if (mismatch_count == 0 && responses_owed == 0)
         $display("fat12_cluster_table: match");
      else
         $display("fat12_cluster_table: mismatch");
      $finish;
   end

endmodule
